/* hw/rtl/bkx_pkg.sv */
// Shared types, character codes and constants of the BibTeX key extractor.
// No dependencies; imported by every module of the block.
package bkx_pkg;

    localparam int MAX_KEY_LEN_DEF = 64;
    localparam int DEPTH_BITS_DEF  = 16;
    localparam int LEN_W           = 7;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [2:0] TYPE_COUNT_MAX = 3'd7;
    localparam logic [2:0] TYPE_COUNT_END = 3'd6;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TYPE = 2'd1,
        PH_KEY  = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } key_desc_t;

    function automatic logic [7:0] comment_lower(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h63;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h6D;
            3'd3:    ch = 8'h6D;
            3'd4:    ch = 8'h65;
            3'd5:    ch = 8'h6E;
            3'd6:    ch = 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] comment_upper(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h43;
            3'd1:    ch = 8'h4F;
            3'd2:    ch = 8'h4D;
            3'd3:    ch = 8'h4D;
            3'd4:    ch = 8'h45;
            3'd5:    ch = 8'h4E;
            3'd6:    ch = 8'h54;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/bibtex_entry_key_extractor_unit.sv */
// BibTeX entry key extractor. The input takes one text byte per cycle while a
// key bank is free; each finished key is sent out one byte per cycle while
// key_stall is low, read from a registered two-bank key memory, with key_last on
// its final byte. The input stalls only while both banks hold keys not yet fully
// sent, so up to two keys may wait at once.
// Depends on bkx_pkg, bkx_front, bkx_desc_fifo and bkx_back.
module bibtex_entry_key_extractor_unit
    import bkx_pkg::*;
#(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF,
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] in_byte,
    input  logic       file_start,
    output logic       key_valid,
    input  logic       key_stall,
    output logic [7:0] key_byte,
    output logic       key_last,
    output logic       key_truncated
);

    localparam int IDXW = $clog2(MAX_KEY_LEN);

    logic            accept;
    logic            wr_en, wr_bank;
    logic [IDXW-1:0] wr_idx;
    logic [7:0]      wr_data;
    logic            push, pop, desc_valid, full;
    key_desc_t       push_desc, desc;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    bkx_front #(
        .MAX_KEY_LEN (MAX_KEY_LEN),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .file_start (file_start),
        .wr_en      (wr_en),
        .wr_bank    (wr_bank),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data),
        .push       (push),
        .push_desc  (push_desc)
    );

    bkx_desc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .desc_valid (desc_valid),
        .desc       (desc),
        .full       (full)
    );

    bkx_back #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_bank       (wr_bank),
        .wr_idx        (wr_idx),
        .wr_data       (wr_data),
        .desc_valid    (desc_valid),
        .desc          (desc),
        .pop           (pop),
        .key_valid     (key_valid),
        .key_stall     (key_stall),
        .key_byte      (key_byte),
        .key_last      (key_last),
        .key_truncated (key_truncated)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("key descriptor pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> desc_valid)
        else $error("key descriptor popped from an empty queue");

    a_trunc_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid && !key_stall && !key_last) |=>
            (!key_valid || (key_truncated == $past(key_truncated))))
        else $error("truncation flag changed inside one key");

    a_no_write_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && desc_valid) |-> (wr_bank != desc.bank))
        else $error("key byte written into the bank being sent");

endmodule

/* hw/rtl/bkx_front.sv */
// Front end: byte parser state machine that writes key bytes into a key bank
// and hands finished keys to the descriptor queue. Depends on bkx_pkg.
module bkx_front
    import bkx_pkg::*;
#(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF,
    parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
    localparam int IDXW       = $clog2(MAX_KEY_LEN)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            file_start,
    output logic            wr_en,
    output logic            wr_bank,
    output logic [IDXW-1:0] wr_idx,
    output logic [7:0]      wr_data,
    output logic            push,
    output key_desc_t       push_desc
);

    localparam logic [LEN_W-1:0]      LEN_MAX   = LEN_W'(MAX_KEY_LEN);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    phase_t                phase_reg, phase_next, phase_eff;
    logic [2:0]            tcount_reg, tcount_next, tcount_eff;
    logic                  cand_reg, cand_next, cand_eff;
    logic                  brace_reg, brace_next, brace_eff;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next, depth_eff;
    logic [LEN_W-1:0]      len_reg, len_next, len_eff;
    logic                  ovf_reg, ovf_next, ovf_eff;
    logic                  bank_reg, bank_next;

    logic       is_ws, is_open_any, is_end, is_drop, type_match;
    logic [7:0] open_ch, close_ch;

    assign phase_eff  = file_start ? PH_IDLE : phase_reg;
    assign tcount_eff = file_start ? 3'd0 : tcount_reg;
    assign cand_eff   = file_start ? 1'b0 : cand_reg;
    assign brace_eff  = file_start ? 1'b0 : brace_reg;
    assign depth_eff  = file_start ? '0 : depth_reg;
    assign len_eff    = file_start ? '0 : len_reg;
    assign ovf_eff    = file_start ? 1'b0 : ovf_reg;

    assign open_ch     = brace_eff ? CH_LBRACE : CH_LPAREN;
    assign close_ch    = brace_eff ? CH_RBRACE : CH_RPAREN;
    assign is_ws       = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                         (in_byte == CH_LF) || (in_byte == CH_CR);
    assign is_open_any = (in_byte == CH_LPAREN) || (in_byte == CH_LBRACE);
    assign is_end      = (in_byte == CH_COMMA) || (in_byte == close_ch);
    assign is_drop     = (in_byte == CH_EQUAL) || (in_byte == CH_QUOTE);
    assign type_match  = cand_eff && (tcount_eff < TYPE_COUNT_MAX) &&
                         ((in_byte == comment_lower(tcount_eff)) ||
                          (in_byte == comment_upper(tcount_eff)));

    always_comb
    begin
        phase_next  = phase_reg;
        tcount_next = tcount_reg;
        cand_next   = cand_reg;
        brace_next  = brace_reg;
        depth_next  = depth_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        bank_next   = bank_reg;
        if (accept)
        begin
            phase_next  = phase_eff;
            tcount_next = tcount_eff;
            cand_next   = cand_eff;
            brace_next  = brace_eff;
            depth_next  = depth_eff;
            len_next    = len_eff;
            ovf_next    = ovf_eff;
            case (phase_eff)
                PH_IDLE:
                begin
                    if (in_byte == CH_AT)
                    begin
                        phase_next  = PH_TYPE;
                        cand_next   = 1'b1;
                        tcount_next = 3'd0;
                    end
                end
                PH_TYPE:
                begin
                    if (is_open_any)
                    begin
                        brace_next = (in_byte == CH_LBRACE);
                        depth_next = DEPTH_BITS'(1);
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        phase_next = PH_KEY;
                    end
                    else if (type_match)
                    begin
                        if (tcount_eff == TYPE_COUNT_END)
                            phase_next = PH_IDLE;
                    end
                    else
                    begin
                        cand_next = 1'b0;
                    end
                    if (tcount_eff < TYPE_COUNT_MAX)
                        tcount_next = tcount_eff + 3'd1;
                end
                PH_KEY:
                begin
                    if (!is_ws)
                    begin
                        if (is_end)
                        begin
                            phase_next = PH_BODY;
                            if (len_eff != '0)
                                bank_next = ~bank_reg;
                        end
                        else if (is_drop)
                            phase_next = PH_BODY;
                        else if (len_eff < LEN_MAX)
                            len_next = len_eff + LEN_W'(1);
                        else
                            ovf_next = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (in_byte == open_ch)
                    begin
                        if (depth_eff != DEPTH_MAX)
                            depth_next = depth_eff + DEPTH_BITS'(1);
                    end
                    else if (in_byte == close_ch)
                    begin
                        if (depth_eff <= DEPTH_BITS'(1))
                        begin
                            depth_next = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                            depth_next = depth_eff - DEPTH_BITS'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        wr_en          = 1'b0;
        push           = 1'b0;
        wr_bank        = bank_reg;
        wr_idx         = len_eff[IDXW-1:0];
        wr_data        = in_byte;
        push_desc.bank = bank_reg;
        push_desc.len  = len_eff;
        push_desc.ovf  = ovf_eff;
        case (phase_eff)
            PH_KEY:
            begin
                if (accept && !is_ws)
                begin
                    if (is_end)
                        push = (len_eff != '0);
                    else if (!is_drop && (len_eff < LEN_MAX))
                        wr_en = 1'b1;
                end
            end
            default:
            begin
                wr_en = 1'b0;
                push  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tcount_reg <= 3'd0;
            cand_reg   <= 1'b0;
            brace_reg  <= 1'b0;
            depth_reg  <= '0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tcount_reg <= tcount_next;
            cand_reg   <= cand_next;
            brace_reg  <= brace_next;
            depth_reg  <= depth_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            bank_reg   <= bank_next;
        end
    end

endmodule

/* hw/rtl/bkx_desc_fifo.sv */
// Two-entry queue of finished key descriptors between front and back end.
// Depends on bkx_pkg.
module bkx_desc_fifo
    import bkx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  key_desc_t push_desc,
    input  logic      pop,
    output logic      desc_valid,
    output key_desc_t desc,
    output logic      full
);

    key_desc_t  entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign desc_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign desc       = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/bkx_back.sv */
// Back end: two-bank key buffer memory and the emitter that reads one key byte
// per cycle, while key_stall does not hold the output, into the output register. Depends on bkx_pkg.
module bkx_back
    import bkx_pkg::*;
#(
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF,
    localparam int IDXW       = $clog2(MAX_KEY_LEN)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic            wr_bank,
    input  logic [IDXW-1:0] wr_idx,
    input  logic [7:0]      wr_data,
    input  logic            desc_valid,
    input  key_desc_t       desc,
    output logic            pop,
    output logic            key_valid,
    input  logic            key_stall,
    output logic [7:0]      key_byte,
    output logic            key_last,
    output logic            key_truncated
);

    localparam int MEM_DEPTH = 2 * (2 ** IDXW);

    logic [7:0]       mem [MEM_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic             last_reg, last_next;
    logic             trunc_reg, trunc_next;
    logic             issue, is_last;
    logic [IDXW:0]    rd_addr;

    assign issue   = desc_valid && (!valid_reg || !key_stall);
    assign is_last = ((idx_reg + LEN_W'(1)) == desc.len);
    assign rd_addr = {desc.bank, idx_reg[IDXW-1:0]};
    assign pop     = issue && is_last;

    assign key_valid     = valid_reg;
    assign key_byte      = rd_data_reg;
    assign key_last      = last_reg;
    assign key_truncated = trunc_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = key_stall ? valid_reg : 1'b0;
        last_next  = last_reg;
        trunc_next = trunc_reg;
        if (issue)
        begin
            idx_next   = is_last ? '0 : idx_reg + LEN_W'(1);
            valid_next = 1'b1;
            last_next  = is_last;
            trunc_next = desc.ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{wr_bank, wr_idx}] <= wr_data;
        if (issue)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            trunc_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            trunc_reg <= trunc_next;
        end
    end

endmodule

/* sim/tb_bibtex_entry_key_extractor_unit.sv */
// Self-checking testbench for bibtex_entry_key_extractor_unit: drives BibTeX text
// bytes, predicts every emitted key byte and checks the key output stream.
// Depends on bkx_pkg and the RTL of the key extractor.
`timescale 1ns / 100ps

module tb_bibtex_entry_key_extractor_unit;
    import bkx_pkg::*;

    localparam int    CYCLE_LIMIT = 1_000_000;
    localparam int    DRAIN_WAIT  = 20;
    localparam string WORD_LC     = "comment";
    localparam string WORD_UC     = "COMMENT";

    typedef struct packed {
        logic [7:0] kbyte;
        logic       is_last;
        logic       trunc;
    } key_result_t;

    class entry_key_tracker;
        phase_t                    phase;
        logic [2:0]                type_cnt;
        logic                      comment_cand;
        logic                      curly;
        logic [DEPTH_BITS_DEF-1:0] depth;
        logic [7:0]                key_mem [MAX_KEY_LEN_DEF];
        logic [LEN_W-1:0]          key_len;
        logic                      key_ovf;
        key_result_t               expected_keys [$];
        int                        predicted;
        int                        errors;

        function new();
            clear_parse();
            predicted = 0;
            errors    = 0;
        endfunction

        function void clear_parse();
            phase        = PH_IDLE;
            type_cnt     = '0;
            comment_cand = 1'b0;
            curly        = 1'b0;
            depth        = '0;
            key_len      = '0;
            key_ovf      = 1'b0;
        endfunction

        function void note_byte(input logic [7:0] c, input logic fs);
            logic [7:0] open_ch;
            logic [7:0] close_ch;
            if (fs)
                clear_parse();
            open_ch  = curly ? CH_LBRACE : CH_LPAREN;
            close_ch = curly ? CH_RBRACE : CH_RPAREN;
            case (phase)
                PH_IDLE:
                begin
                    if (c == CH_AT)
                    begin
                        phase        = PH_TYPE;
                        comment_cand = 1'b1;
                        type_cnt     = '0;
                    end
                end
                PH_TYPE:
                begin
                    if (c == CH_LPAREN || c == CH_LBRACE)
                    begin
                        curly   = (c == CH_LBRACE);
                        depth   = DEPTH_BITS_DEF'(1);
                        key_len = '0;
                        key_ovf = 1'b0;
                        phase   = PH_KEY;
                    end
                    else if (comment_cand && type_cnt < TYPE_COUNT_MAX &&
                             (c == WORD_LC[type_cnt] || c == WORD_UC[type_cnt]))
                    begin
                        if (type_cnt == TYPE_COUNT_END)
                            phase = PH_IDLE;
                    end
                    else
                    begin
                        comment_cand = 1'b0;
                    end
                    if (type_cnt < TYPE_COUNT_MAX)
                        type_cnt++;
                end
                PH_KEY:
                begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
                    begin
                    end
                    else if (c == CH_COMMA || c == close_ch)
                    begin
                        for (int i = 0; i < key_len; i++)
                        begin
                            expected_keys.push_back(
                                key_result_t'{key_mem[i], (i + 1 == key_len), key_ovf});
                            predicted++;
                        end
                        phase = PH_BODY;
                    end
                    else if (c == CH_EQUAL || c == CH_QUOTE)
                    begin
                        phase = PH_BODY;
                    end
                    else if (key_len < MAX_KEY_LEN_DEF)
                    begin
                        key_mem[key_len] = c;
                        key_len++;
                    end
                    else
                    begin
                        key_ovf = 1'b1;
                    end
                end
                default:
                begin
                    if (c == open_ch)
                    begin
                        if (depth != '1)
                            depth++;
                    end
                    else if (c == close_ch)
                    begin
                        if (depth <= 1)
                        begin
                            depth = '0;
                            phase = PH_IDLE;
                        end
                        else
                        begin
                            depth--;
                        end
                    end
                end
            endcase
        endfunction

        function void check_key_byte(input logic [7:0] kb, input logic kl, input logic kt);
            key_result_t want;
            if (expected_keys.size() == 0)
            begin
                $error("key_byte: none expected, got %h", kb);
                errors++;
                return;
            end
            want = expected_keys.pop_front();
            if (kb !== want.kbyte)
            begin
                $error("key_byte: expected %h, got %h", want.kbyte, kb);
                errors++;
            end
            if (kl !== want.is_last)
            begin
                $error("key_last: expected %b, got %b", want.is_last, kl);
                errors++;
            end
            if (kt !== want.trunc)
            begin
                $error("key_truncated: expected %b, got %b", want.trunc, kt);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n         = 1'b0;
    logic       byte_valid    = 1'b0;
    logic       byte_stall;
    logic [7:0] in_byte       = 8'h00;
    logic       file_start    = 1'b0;
    logic       key_valid;
    logic       key_stall     = 1'b0;
    logic [7:0] key_byte;
    logic       key_last;
    logic       key_truncated;

    entry_key_tracker tracker = new();
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    int  bytes_sent     = 0;
    int  cycle_count    = 0;
    logic restart_next  = 1'b0;

    bibtex_entry_key_extractor_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .in_byte       (in_byte),
        .file_start    (file_start),
        .key_valid     (key_valid),
        .key_stall     (key_stall),
        .key_byte      (key_byte),
        .key_last      (key_last),
        .key_truncated (key_truncated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_bibtex_entry_key_extractor_unit: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (key_valid && !key_stall)
                tracker.check_key_byte(key_byte, key_last, key_truncated);
            key_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Call right after a rising edge; returns at the edge that completes the transfer.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        in_byte    <= b;
        file_start <= fs;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        tracker.note_byte(b, fs);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    endfunction

    task automatic send_random_entry();
        int         pick;
        int         key_n;
        int         lvl;
        logic       fs;
        logic       curly;
        logic [7:0] open_ch;
        logic [7:0] close_ch;
        logic [7:0] c;
        fs = restart_next || ($urandom_range(9) == 0);
        restart_next = 1'b0;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            repeat ($urandom_range(12, 4))
            begin
                send_byte(8'($urandom()), fs);
                fs = 1'b0;
            end
            restart_next = 1'b1;
            return;
        end
        repeat ($urandom_range(2))
        begin
            send_byte(8'($urandom()), fs);
            fs = 1'b0;
        end
        send_byte(CH_AT, fs);
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            lvl = $urandom_range(1) ? 7 : $urandom_range(6, 1);
            for (int i = 0; i < lvl; i++)
                send_byte($urandom_range(1) ? WORD_UC[i] : WORD_LC[i], 1'b0);
            if (lvl < 7)
                send_byte(rand_letter(), 1'b0);
        end
        else if (pick < 25)
        begin
            repeat ($urandom_range(12, 8))
                send_byte(rand_letter(), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(7, 2))
                send_byte(rand_letter(), 1'b0);
        end
        curly    = 1'($urandom_range(1));
        open_ch  = curly ? CH_LBRACE : CH_LPAREN;
        close_ch = curly ? CH_RBRACE : CH_RPAREN;
        send_byte(open_ch, 1'b0);
        key_n = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(8);
        repeat (key_n)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                case ($urandom_range(3))
                    0:       c = CH_SPACE;
                    1:       c = CH_TAB;
                    2:       c = CH_LF;
                    default: c = CH_CR;
                endcase
            end
            else if (pick < 25)
                c = 8'($urandom());
            else if (pick < 35)
                c = 8'h30 + 8'($urandom_range(9));
            else
                c = rand_letter();
            send_byte(c, 1'b0);
        end
        pick = $urandom_range(99);
        send_byte(pick < 80 ? CH_COMMA : pick < 90 ? close_ch :
                  pick < 95 ? CH_EQUAL : CH_QUOTE, 1'b0);
        lvl = 1;
        repeat ($urandom_range(10))
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                c = open_ch;
                lvl++;
            end
            else if (pick < 35 && lvl > 1)
            begin
                c = close_ch;
                lvl--;
            end
            else if (pick < 40)
                c = curly ? CH_RPAREN : CH_RBRACE;
            else
                c = rand_letter();
            send_byte(c, 1'b0);
        end
        repeat (lvl)
            send_byte(close_ch, 1'b0);
    endtask

    initial
    begin
        int src_pct [4];
        int sink_pct [4];
        int phase_bytes;
        int phase_keys;
        src_pct  = '{0, 82, 0, 32};
        sink_pct = '{0, 0, 82, 32};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_text("@article{Key1 2,\n title={A {B}}}\n");
        send_text("@CoMmEnT{ignored, x}");
        send_text("@commentary{ck,}");
        send_text("@comMenX{ck2,}");
        send_text("@inproceedingsxx{lt,}");
        send_text("@misc(pk) )");
        send_text("@misc(a}b) x)");
        send_text("@book{,}@book{ }");
        send_text("@book{x=1}@book{y\"z\"}");
        send_text("@a{");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_text(",}");
        send_text("@a(");
        repeat (MAX_KEY_LEN_DEF + 1)
            send_byte(rand_letter(), 1'b0);
        send_text("))@a{abc");
        send_byte(CH_AT, 1'b1);
        send_text("x{k2,}");

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct   = src_pct[p];
            sink_stall_pct = sink_pct[p];
            phase_bytes    = bytes_sent;
            phase_keys     = tracker.predicted;
            while (bytes_sent - phase_bytes < 12 || tracker.predicted - phase_keys < 4)
                send_random_entry();
        end
        byte_valid <= 1'b0;

        while (tracker.expected_keys.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (tracker.errors == 0)
            $display("tb_bibtex_entry_key_extractor_unit: done, clean");
        else
            $display("tb_bibtex_entry_key_extractor_unit: done, errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/bkx_pkg.sv
hw/rtl/bkx_front.sv
hw/rtl/bkx_desc_fifo.sv
hw/rtl/bkx_back.sv
hw/rtl/bibtex_entry_key_extractor_unit.sv
sim/tb_bibtex_entry_key_extractor_unit.sv
